FILE: rtl/dpsm_pkg.sv
`timescale 1ns / 1ps

package dpsm_pkg;

   // default timestamp width in bits
   localparam int TIME_WIDTH_DEF = 48;

   // quotient and divisor width of the divider
   localparam int QUOT_WIDTH = 32;

   // verdict codes
   localparam logic [2:0] V_RISING      = 3'd0;
   localparam logic [2:0] V_REPEAT_LOW  = 3'd1;
   localparam logic [2:0] V_RISE_BOUNCE = 3'd2;
   localparam logic [2:0] V_DEBOUNCE    = 3'd3;
   localparam logic [2:0] V_ACCEPTED    = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [1:0] CSR_WHEEL    = 2'd1;
   localparam logic [1:0] CSR_INIT_LVL = 2'd2;

endpackage : dpsm_pkg

FILE: rtl/dpsm_divider.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The dividend is taken
// MSB first; a short dividend is left-aligned by the caller and run for
// fewer steps. Only the low QUOT_WIDTH quotient bits are kept.
module dpsm_divider #(
   parameter int DIVIDEND_WIDTH = dpsm_pkg::TIME_WIDTH_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   input  logic [DIVIDEND_WIDTH-1:0]                 dividend,
   input  logic [dpsm_pkg::QUOT_WIDTH-1:0]           divisor,
   input  logic [$clog2(DIVIDEND_WIDTH+1)-1:0]       steps,
   output logic                                      busy,
   output logic                                      done,
   output logic [dpsm_pkg::QUOT_WIDTH-1:0]           quotient
);
   import dpsm_pkg::*;

   localparam int STEP_W = $clog2(DIVIDEND_WIDTH + 1);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [STEP_W-1:0]         cnt_ff, cnt_in;
   logic [DIVIDEND_WIDTH-1:0] num_ff, num_in;
   logic [QUOT_WIDTH-1:0]     den_ff, den_in;
   logic [QUOT_WIDTH-1:0]     rem_ff, rem_in;
   logic [QUOT_WIDTH-1:0]     quo_ff, quo_in;
   logic [QUOT_WIDTH:0]       trial;
   logic [QUOT_WIDTH:0]       diff;

   // one trial subtraction per step
   assign trial = {rem_ff, num_ff[DIVIDEND_WIDTH-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         cnt_in = cnt_ff - STEP_W'(1);
         if (!diff[QUOT_WIDTH]) begin
            rem_in = diff[QUOT_WIDTH-1:0];
            quo_in = {quo_ff[QUOT_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[QUOT_WIDTH-1:0];
            quo_in = {quo_ff[QUOT_WIDTH-2:0], 1'b0};
         end
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

   // a new division never starts on top of a running one
   assert property (@(posedge clock) disable iff (reset) start |-> !busy_ff)
      else $error("divider started while busy");

   // done follows the last step of a running division
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("divider done without a running division");

   // the step counter never runs out while busy
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0)
      else $error("divider busy with zero steps left");

endmodule : dpsm_divider

FILE: rtl/debounced_pulse_speed_meter.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Beat contents
// req      in         req_valid/req_ready  req_time_us, req_pin_level
// rsp      out        rsp_valid/rsp_ready  rsp_verdict, rsp_pulse_total,
//                                          rsp_period_ms, rsp_speed_kmh_x10
// csr      in         csr_we               csr_index, csr_wdata
//
// One beat at a time: a req beat is taken only when idle; a nonzero
// speed is divided out in 25 steps on the divider, and an accepted
// pulse that measures a new interval adds the ms conversion (7 bits
// per cycle by reciprocal multiply). reset is synchronous, active high;
// it clears sequencer, pulse history, settings, rsp_valid; no clearing pass.
// The result register holds a finished beat while the next req beat is taken;
// a stalled rsp holds the sequencer only at its final step.
module debounced_pulse_speed_meter #(
   parameter int TIME_WIDTH = dpsm_pkg::TIME_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // event beats
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [TIME_WIDTH-1:0]            req_time_us,
   input  logic                             req_pin_level,
   // result beats
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [2:0]                       rsp_verdict,
   output logic [dpsm_pkg::QUOT_WIDTH-1:0]  rsp_pulse_total,
   output logic [dpsm_pkg::QUOT_WIDTH-1:0]  rsp_period_ms,
   output logic [24:0]                      rsp_speed_kmh_x10,
   // register writes
   input  logic                             csr_we,
   input  logic [1:0]                       csr_index,
   input  logic [15:0]                      csr_wdata
);
   import dpsm_pkg::*;

   localparam int DEB_W  = 26;
   localparam int SPD_W  = 25;
   localparam int STEP_W = $clog2(SPD_W + 1);

   localparam logic [DEB_W-1:0] US_PER_MS    = DEB_W'(1000);
   localparam logic [DEB_W-1:0] GUARD_MAX_US = DEB_W'(10000);
   localparam logic [SPD_W-1:0] KMH_FACTOR   = SPD_W'(360);
   localparam logic [31:0]      STALE_US     = 32'd7200000;
   localparam logic [63:0]      SAT_LIMIT_US = 64'hFFFF_FFFF * 64'd1000;

   // ms conversion: an unsaturated interval fits 42 bits, taken 7 bits a step
   localparam int          MS_W       = 42;
   localparam int          MS_DIGIT   = 7;
   localparam logic [2:0]  MS_STEPS   = 3'(MS_W / MS_DIGIT);
   localparam int          MS_SHIFT   = 21;
   localparam logic [14:0] MS_RECIP   = 15'd16778;   // ceil(2^21 / 125)
   localparam logic [16:0] MS_DIVISOR = 17'(US_PER_MS);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_DIVI  = 3'd2;
   localparam logic [2:0] S_MUL   = 3'd3;
   localparam logic [2:0] S_DIVS  = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic                  pin_ff, pin_in;
   logic [TIME_WIDTH-1:0] now_ff, now_in;
   logic [TIME_WIDTH-1:0] el_rise_ff, el_rise_in;
   logic [TIME_WIDTH-1:0] el_acc_ff, el_acc_in;
   logic [DEB_W-1:0]      deb_us_ff, deb_us_in;
   logic                  lvl_high_ff, lvl_high_in;
   logic [TIME_WIDTH-1:0] rise_ff, rise_in;
   logic [TIME_WIDTH-1:0] acc_time_ff, acc_time_in;
   logic [QUOT_WIDTH-1:0] count_ff, count_in;
   logic [QUOT_WIDTH-1:0] interval_ff, interval_in;
   logic                  seen_ff, seen_in;
   logic [15:0]           debounce_ff, debounce_in;
   logic [15:0]           wheel_ff, wheel_in;
   logic [2:0]            verdict_ff, verdict_in;
   logic                  stale_ff, stale_in;
   logic [SPD_W-1:0]      prod_ff, prod_in;
   logic [SPD_W-1:0]      speed_ff, speed_in;
   logic [MS_W-1:0]       ms_num_ff, ms_num_in;
   logic [9:0]            ms_rem_ff, ms_rem_in;
   logic [QUOT_WIDTH-1:0] ms_quo_ff, ms_quo_in;
   logic [2:0]            ms_cnt_ff, ms_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [2:0]            rsp_verdict_ff, rsp_verdict_in;
   logic [QUOT_WIDTH-1:0] rsp_total_ff, rsp_total_in;
   logic [QUOT_WIDTH-1:0] rsp_period_ff, rsp_period_in;
   logic [SPD_W-1:0]      rsp_speed_ff, rsp_speed_in;

   logic                  req_fire;
   logic                  out_load;
   logic [DEB_W-1:0]      guard_us;
   logic                  is_bounce;
   logic                  is_debounce;
   logic                  is_sat;
   logic                  accept_now;
   logic                  speed_zero;

   logic [16:0]           ms_x;
   logic [28:0]           ms_prod;
   logic [MS_DIGIT-1:0]   ms_digit;
   logic [16:0]           ms_back;
   logic [16:0]           ms_left;

   logic                  div_start;
   logic [SPD_W-1:0]      div_dividend;
   logic [QUOT_WIDTH-1:0] div_divisor;
   logic [STEP_W-1:0]     div_steps;
   logic                  div_busy;
   logic                  div_done;
   logic [QUOT_WIDTH-1:0] div_quot;

   assign req_fire = req_valid && req_ready;
   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   // pulse qualification on registered elapsed times
   assign guard_us    = (deb_us_ff < GUARD_MAX_US) ? deb_us_ff : GUARD_MAX_US;
   assign is_bounce   = el_rise_ff < TIME_WIDTH'(guard_us);
   assign is_debounce = el_acc_ff < TIME_WIDTH'(deb_us_ff);
   assign is_sat      = 64'(el_acc_ff) > SAT_LIMIT_US;
   assign accept_now  = !pin_ff && was_accept_ok();
   assign speed_zero  = stale_ff || (interval_ff == '0) || (interval_ff == '1);

   function automatic logic was_accept_ok();
      return lvl_high_ff && !is_bounce && !is_debounce;
   endfunction

   // one long-division digit by 1000: x/1000 == (x/8)/125, reciprocal exact
   // for x below 128000, remainder stays below 1000
   assign ms_x     = {ms_rem_ff, ms_num_ff[MS_W-1 -: MS_DIGIT]};
   assign ms_prod  = 29'(ms_x[16:3]) * 29'(MS_RECIP);
   assign ms_digit = ms_prod[MS_SHIFT +: MS_DIGIT];
   assign ms_back  = 17'(ms_digit) * MS_DIVISOR;
   assign ms_left  = ms_x - ms_back;

   // divider for the speed from the known interval
   assign div_start    = (state_ff == S_MUL) && !speed_zero;
   assign div_dividend = prod_in;
   assign div_divisor  = interval_ff;
   assign div_steps    = STEP_W'(SPD_W);

   dpsm_divider #(
      .DIVIDEND_WIDTH (SPD_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .steps    (div_steps),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot)
   );

   // sequencer and state update
   always_comb begin
      state_in       = state_ff;
      pin_in         = pin_ff;
      now_in         = now_ff;
      el_rise_in     = el_rise_ff;
      el_acc_in      = el_acc_ff;
      deb_us_in      = deb_us_ff;
      lvl_high_in    = lvl_high_ff;
      rise_in        = rise_ff;
      acc_time_in    = acc_time_ff;
      count_in       = count_ff;
      interval_in    = interval_ff;
      seen_in        = seen_ff;
      debounce_in    = debounce_ff;
      wheel_in       = wheel_ff;
      verdict_in     = verdict_ff;
      stale_in       = stale_ff;
      prod_in        = KMH_FACTOR * SPD_W'(wheel_ff);
      speed_in       = speed_ff;
      ms_num_in      = ms_num_ff;
      ms_rem_in      = ms_rem_ff;
      ms_quo_in      = ms_quo_ff;
      ms_cnt_in      = ms_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_period_in  = rsp_period_ff;
      rsp_speed_in   = rsp_speed_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               now_in     = req_time_us;
               pin_in     = req_pin_level;
               el_rise_in = req_time_us - rise_ff;
               el_acc_in  = req_time_us - acc_time_ff;
               deb_us_in  = DEB_W'(debounce_ff) * US_PER_MS;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            lvl_high_in = pin_ff;
            // stale check against the time of the last accepted pulse
            stale_in    = !accept_now && (el_acc_ff > TIME_WIDTH'(STALE_US));
            state_in    = S_MUL;
            if (pin_ff) begin
               rise_in    = now_ff;
               verdict_in = V_RISING;
            end else if (!lvl_high_ff) begin
               verdict_in = V_REPEAT_LOW;
            end else if (is_bounce) begin
               verdict_in = V_RISE_BOUNCE;
            end else if (is_debounce) begin
               verdict_in = V_DEBOUNCE;
            end else begin
               verdict_in  = V_ACCEPTED;
               seen_in     = 1'b1;
               acc_time_in = now_ff;
               count_in    = count_ff + QUOT_WIDTH'(1);
               if (seen_ff) begin
                  if (is_sat) begin
                     interval_in = '1;
                  end else begin
                     ms_num_in = MS_W'(el_acc_ff);
                     ms_rem_in = '0;
                     ms_quo_in = '0;
                     ms_cnt_in = MS_STEPS;
                     state_in  = S_DIVI;
                  end
               end
            end
         end
         S_DIVI: begin
            ms_num_in = ms_num_ff << MS_DIGIT;
            ms_rem_in = ms_left[9:0];
            ms_quo_in = {ms_quo_ff[QUOT_WIDTH-MS_DIGIT-1:0], ms_digit};
            ms_cnt_in = ms_cnt_ff - 3'd1;
            if (ms_cnt_ff == 3'd1) begin
               interval_in = {ms_quo_ff[QUOT_WIDTH-MS_DIGIT-1:0], ms_digit};
               state_in    = S_MUL;
            end
         end
         S_MUL: begin
            speed_in = '0;
            state_in = speed_zero ? S_OUT : S_DIVS;
         end
         S_DIVS: begin
            if (div_done) begin
               speed_in = div_quot[SPD_W-1:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_load) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = verdict_ff;
               rsp_total_in   = count_ff;
               rsp_period_in  = interval_ff;
               rsp_speed_in   = speed_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // register writes must arrive only while idle; it is not enforced
      if (csr_we) begin
         case (csr_index)
            CSR_DEBOUNCE: debounce_in = csr_wdata;
            CSR_WHEEL:    wheel_in    = csr_wdata;
            CSR_INIT_LVL: lvl_high_in = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lvl_high_ff  <= 1'b1;
         rise_ff      <= '0;
         acc_time_ff  <= '0;
         count_ff     <= '0;
         interval_ff  <= '1;
         seen_ff      <= 1'b0;
         debounce_ff  <= '0;
         wheel_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lvl_high_ff  <= lvl_high_in;
         rise_ff      <= rise_in;
         acc_time_ff  <= acc_time_in;
         count_ff     <= count_in;
         interval_ff  <= interval_in;
         seen_ff      <= seen_in;
         debounce_ff  <= debounce_in;
         wheel_ff     <= wheel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pin_ff         <= pin_in;
      now_ff         <= now_in;
      el_rise_ff     <= el_rise_in;
      el_acc_ff      <= el_acc_in;
      deb_us_ff      <= deb_us_in;
      verdict_ff     <= verdict_in;
      stale_ff       <= stale_in;
      prod_ff        <= prod_in;
      speed_ff       <= speed_in;
      ms_num_ff      <= ms_num_in;
      ms_rem_ff      <= ms_rem_in;
      ms_quo_ff      <= ms_quo_in;
      ms_cnt_ff      <= ms_cnt_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_period_ff  <= rsp_period_in;
      rsp_speed_ff   <= rsp_speed_in;
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_verdict       = rsp_verdict_ff;
   assign rsp_pulse_total   = rsp_total_ff;
   assign rsp_period_ms     = rsp_period_ff;
   assign rsp_speed_kmh_x10 = rsp_speed_ff;

   // an accepted pulse bumps the count by exactly one
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) && accept_now |=> count_ff == $past(count_ff) + QUOT_WIDTH'(1))
      else $error("accepted pulse did not advance the count");

   // a nonzero speed only comes from a known, nonzero interval
   assert property (@(posedge clock) disable iff (reset)
      out_load && (speed_ff != '0) |-> (interval_ff != '0) && (interval_ff != '1))
      else $error("speed reported without a valid interval");

   // the divider is idle whenever a new event can be taken
   assert property (@(posedge clock) disable iff (reset) req_ready |-> !div_busy)
      else $error("event taken while the divider runs");

   // the speed product holds still while it is divided
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVS) |-> prod_ff == KMH_FACTOR * SPD_W'(wheel_ff))
      else $error("speed product changed during division");

endmodule : debounced_pulse_speed_meter

FILE: tb/tb_debounced_pulse_speed_meter.sv
`timescale 1ns / 1ps

module tb_debounced_pulse_speed_meter;

   import dpsm_pkg::*;

   localparam int TW = dpsm_pkg::TIME_WIDTH_DEF;
   localparam int QW = dpsm_pkg::QUOT_WIDTH;

   // timing and scaling constants
   localparam logic [TW-1:0]   GUARD_MAX_US   = 48'd10000;
   localparam logic [TW-1:0]   STALE_US       = 48'd7200000;
   localparam logic [TW-1:0]   US_PER_MS      = 48'd1000;
   localparam logic [31:0]     KMH_X10_PER_CM = 32'd360;
   localparam longint unsigned SAT_LIMIT_US   = 64'd4294967295 * 64'd1000;

   typedef struct packed {
      logic [2:0]    verdict;
      logic [QW-1:0] pulse_total;
      logic [QW-1:0] period_ms;
      logic [24:0]   speed_kmh_x10;
   } meter_result_type;

   // speed meter state mirror plus queue of expected result beats
   class meter_scoreboard;
      logic [15:0]      deb_ms_set;
      logic [15:0]      wheel_cm;
      logic             initial_level;
      logic             level_high;
      logic [TW-1:0]    rise_time;
      logic [TW-1:0]    accept_time;
      logic [31:0]      accept_count;
      logic [31:0]      last_interval;
      logic             accept_seen;
      meter_result_type expected_q[$];
      int               errors;

      function new();
         deb_ms_set    = '0;
         wheel_cm      = '0;
         initial_level = 1'b1;
         level_high    = 1'b1;
         rise_time     = '0;
         accept_time   = '0;
         accept_count  = '0;
         last_interval = '1;
         accept_seen   = 1'b0;
         errors        = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] val);
         case (idx)
            CSR_DEBOUNCE: deb_ms_set = val;
            CSR_WHEEL:    wheel_cm = val;
            CSR_INIT_LVL: begin
               initial_level = val[0];
               level_high    = val[0];
            end
            default: ;
         endcase
      endfunction

      function int pending_beats();
         return expected_q.size();
      endfunction

      // classify one edge event, update state, queue the expected beat
      function void note_event(logic [TW-1:0] t, logic level);
         logic [TW-1:0] deb_us;
         logic [TW-1:0] guard_us;
         logic [TW-1:0] since_rise;
         logic [TW-1:0] since_accept;
         logic          prev_high;
         meter_result_type r;
         deb_us       = TW'(deb_ms_set) * US_PER_MS;
         guard_us     = (deb_us < GUARD_MAX_US) ? deb_us : GUARD_MAX_US;
         since_rise   = t - rise_time;
         since_accept = t - accept_time;
         prev_high    = level_high;
         level_high   = level;
         if (level) begin
            rise_time = t;
            r.verdict = V_RISING;
         end else if (!prev_high) begin
            r.verdict = V_REPEAT_LOW;
         end else if (since_rise < guard_us) begin
            r.verdict = V_RISE_BOUNCE;
         end else if (since_accept < deb_us) begin
            r.verdict = V_DEBOUNCE;
         end else begin
            // first pulse leaves the interval unknown
            if (accept_seen) begin
               if (64'(since_accept) > SAT_LIMIT_US)
                  last_interval = '1;
               else
                  last_interval = 32'(since_accept / US_PER_MS);
            end
            accept_seen  = 1'b1;
            accept_time  = t;
            accept_count = accept_count + 32'd1;
            r.verdict    = V_ACCEPTED;
         end
         r.pulse_total = accept_count;
         r.period_ms   = last_interval;
         // speed is taken after the state update
         since_accept = t - accept_time;
         if (last_interval == '1 || last_interval == '0 || since_accept > STALE_US)
            r.speed_kmh_x10 = '0;
         else
            r.speed_kmh_x10 = 25'((32'(wheel_cm) * KMH_X10_PER_CM) / last_interval);
         expected_q.push_back(r);
      endfunction

      function void compare_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $error("%s wrong: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic [2:0] verdict, logic [QW-1:0] total,
                                 logic [QW-1:0] period, logic [24:0] speed);
         meter_result_type want;
         if (expected_q.size() == 0) begin
            $error("result beat arrived with nothing expected");
            errors++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("rsp_verdict", want.verdict, verdict);
         compare_field("rsp_pulse_total", want.pulse_total, total);
         compare_field("rsp_period_ms", want.period_ms, period);
         compare_field("rsp_speed_kmh_x10", want.speed_kmh_x10, speed);
      endfunction
   endclass

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   logic [TW-1:0]   req_time_us;
   logic            req_pin_level;
   logic            rsp_valid;
   logic            rsp_ready;
   logic [2:0]      rsp_verdict;
   logic [QW-1:0]   rsp_pulse_total;
   logic [QW-1:0]   rsp_period_ms;
   logic [24:0]     rsp_speed_kmh_x10;
   logic            csr_we;
   logic [1:0]      csr_index;
   logic [15:0]     csr_wdata;

   meter_scoreboard sb;
   int              send_idle_pct;
   int              rcv_stall_pct;
   int              sent_count;
   logic [TW-1:0]   cursor_us;

   debounced_pulse_speed_meter #(
      .TIME_WIDTH(TW)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_time_us       (req_time_us),
      .req_pin_level     (req_pin_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_verdict       (rsp_verdict),
      .rsp_pulse_total   (rsp_pulse_total),
      .rsp_period_ms     (rsp_period_ms),
      .rsp_speed_kmh_x10 (rsp_speed_kmh_x10),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side: random stall, checked at the rising edge
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_verdict, rsp_pulse_total, rsp_period_ms, rsp_speed_kmh_x10);
   end

   // one event beat; valid stays up from the previous beat unless idling
   task automatic send_event(input logic [TW-1:0] t, input logic level);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_time_us   <= t;
      req_pin_level <= level;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      sb.note_event(t, level);
      sent_count++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_beats() != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // drain, reprogram, pick the idling pattern
   task automatic set_phase(input int deb, input int wheel, input int level, input int mode);
      wait_idle();
      write_reg(CSR_DEBOUNCE, 16'(deb));
      write_reg(CSR_WHEEL, 16'(wheel));
      write_reg(CSR_INIT_LVL, 16'(level));
      case (mode)
         0: begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
         1: begin send_idle_pct = 80; rcv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  rcv_stall_pct = 80; end
         default: begin send_idle_pct = 13; rcv_stall_pct = 13; end
      endcase
   endtask

   // gap between edges, scaled to the current debounce setting
   function automatic logic [TW-1:0] pick_gap();
      int unsigned deb_us;
      deb_us = int'(sb.deb_ms_set) * 1000;
      case ($urandom_range(19))
         0, 1:          return TW'($urandom_range(30));
         2, 3, 4, 5:    return TW'($urandom_range(deb_us + 10));
         6, 7, 8, 9, 10, 11, 12, 13:
                        return TW'(deb_us) + TW'($urandom_range(30000));
         14, 15, 16:    return TW'($urandom_range(8000000));
         17, 18:        return STALE_US - 48'd2 + TW'($urandom_range(4));
         // around the interval saturation point
         default:       return {6'd0, 10'(990 + $urandom_range(30)), 32'($urandom)};
      endcase
   endfunction

   task automatic run_random_phase(input int n_beats);
      int            stop_at;
      int            pick;
      logic [TW-1:0] t;
      stop_at = sent_count + n_beats;
      while (sent_count < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 65) begin
            // clean pulse: rise then fall
            t = cursor_us + pick_gap();
            send_event(t, 1'b1);
            t = t + pick_gap();
            send_event(t, 1'b0);
         end else if (pick < 80) begin
            // contact bounce around a pulse
            t = cursor_us + pick_gap();
            send_event(t, 1'b1);
            repeat ($urandom_range(1, 4)) begin
               t = t + TW'($urandom_range(12000));
               send_event(t, 1'($urandom_range(1)));
            end
            t = t + pick_gap();
            send_event(t, 1'b0);
         end else if (pick < 92) begin
            t = cursor_us + TW'($urandom_range(20000));
            send_event(t, 1'($urandom_range(1)));
         end else begin
            // jump anywhere, often close to the wrap point
            if ($urandom_range(1))
               t = {16'($urandom), 32'($urandom)};
            else
               t = '1 - TW'($urandom_range(50000));
            send_event(t, 1'($urandom_range(1)));
         end
         cursor_us = t;
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_time_us   = '0;
      req_pin_level = 1'b0;
      csr_we        = 1'b0;
      csr_index     = CSR_DEBOUNCE;
      csr_wdata     = '0;
      send_idle_pct = 0;
      rcv_stall_pct = 0;
      sent_count    = 0;
      cursor_us     = '0;
      sb            = new();
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // reset defaults: pulse at time zero, repeated low, zero interval
      send_event(48'd0, 1'b0);
      send_event(48'd0, 1'b0);
      send_event(48'd500, 1'b1);
      send_event(48'd1500, 1'b0);
      send_event(48'd1500, 1'b1);
      send_event(48'd1700, 1'b0);

      // debounce above the 10 ms guard cap, pin starts low
      set_phase(20, 65535, 0, 0);
      send_event(48'd3000, 1'b0);
      send_event(48'd4000, 1'b1);
      send_event(48'd4500, 1'b0);
      send_event(48'd20000, 1'b1);
      send_event(48'd30500, 1'b0);
      send_event(48'd31000, 1'b1);
      send_event(48'd41500, 1'b0);
      send_event(48'd50000, 1'b1);
      send_event(48'd60500, 1'b0);
      // exactly at, then just past, the stale limit
      send_event(48'd7260500, 1'b1);
      send_event(48'd7260501, 1'b1);

      // no debounce: top speed, saturated interval, timestamp wrap
      set_phase(0, 65535, 1, 3);
      send_event(48'd8000000, 1'b0);
      send_event(48'd8000100, 1'b1);
      send_event(48'd8001000, 1'b0);
      send_event(48'h0400_0000_0000 + 48'd8000995, 1'b1);
      send_event(48'h0400_0000_0000 + 48'd8001000, 1'b0);
      send_event(48'hFFFF_FFFF_FFFF, 1'b1);
      send_event(48'd1000, 1'b0);
      cursor_us = 48'd1000;

      // random phases, fixed extremes first
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: set_phase(0, 65535, 1, p % 4);
            1: set_phase(65535, 0, 0, p % 4);
            2: set_phase(20, 1500, 1, p % 4);
            3: set_phase(5, 200, 0, p % 4);
            default:
               set_phase(($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(40),
                         $urandom_range(65535), $urandom_range(1), p % 4);
         endcase
         run_random_phase(180);
      end

      wait_idle();
      repeat (100) @(negedge clock);
      if (sb.errors == 0 && sb.pending_beats() == 0) begin
         $display("debounced_pulse_speed_meter: match");
      end else begin
         if (sb.pending_beats() != 0)
            $error("%0d expected result beats never arrived", sb.pending_beats());
         $display("debounced_pulse_speed_meter: mismatch");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("debounced_pulse_speed_meter: mismatch");
      $finish;
   end

endmodule
